[sv/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, off while reset is high.
`define PPG_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ppgdc assertion failed");

// Concurrent assertion, checked through reset as well.
`define PPG_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ppgdc assertion failed");

`endif

[sv/ppgdc_pkg.sv]
// Shared types and constants for the PPG DC blocker and boxcar smoother.
// No dependencies.
`timescale 1ns / 1ps

package ppgdc_pkg;

  localparam int X_W     = 18;
  localparam int SIG_W   = 28;
  localparam int FRAC_W  = 8;
  localparam int ALPHA_W = 15;
  localparam int FIFO_D  = 8;
  localparam int FIFO_AW = 3;
  localparam int FIFO_CW = 4;

  typedef logic [X_W-1:0]            raw_t;
  typedef logic signed [SIG_W-1:0]   sig_t;
  typedef logic [ALPHA_W-1:0]        alpha_t;
  typedef logic [FIFO_CW-1:0]        fcnt_t;

  localparam alpha_t ALPHA_RESET  = 15'd31130;
  localparam logic   SMOOTH_RESET = 1'b1;
  localparam sig_t   SIG_MAX      = 28'sh7FFFFFF;
  localparam sig_t   SIG_MIN      = 28'sh8000000;

  typedef struct packed {
    alpha_t alpha;
    logic   smooth;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic bypass;
    logic neg;
  } stg_t;

endpackage

[sv/ppgdc_regs.sv]
// APB configuration registers: alpha and smoothing enable.
// Depends on ppgdc_pkg.
`timescale 1ns / 1ps

module ppgdc_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ppgdc_pkg::cfg_t    cfg
);

  localparam logic [2:0] ADDR_ALPHA_LO  = 3'd0;
  localparam logic [2:0] ADDR_ALPHA_HI  = 3'd3;
  localparam logic [2:0] ADDR_SMOOTH_LO = 3'd4;
  localparam logic [2:0] ADDR_SMOOTH_HI = 3'd7;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha  <= ppgdc_pkg::ALPHA_RESET;
      cfg.smooth <= ppgdc_pkg::SMOOTH_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr) inside
        [ADDR_ALPHA_LO:ADDR_ALPHA_HI]:   cfg.alpha  <= pwdata[ppgdc_pkg::ALPHA_W-1:0];
        [ADDR_SMOOTH_LO:ADDR_SMOOTH_HI]: cfg.smooth <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr) inside
      [ADDR_ALPHA_LO:ADDR_ALPHA_HI]:
        prdata = {{(32-ppgdc_pkg::ALPHA_W){1'b0}}, cfg.alpha};
      [ADDR_SMOOTH_LO:ADDR_SMOOTH_HI]:
        prdata = {31'd0, cfg.smooth};
      default: prdata = 32'd0;
    endcase
  end

endmodule

[sv/ppgdc_filter.sv]
// Input register and first-order DC-removal filter with saturation.
// Depends on ppgdc_pkg.
`timescale 1ns / 1ps

module ppgdc_filter (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  ppgdc_pkg::raw_t     sample,
  input  ppgdc_pkg::alpha_t   alpha,
  output logic                valid0,
  output logic                valid1,
  output ppgdc_pkg::sig_t     y
);

  localparam int X_W   = ppgdc_pkg::X_W;
  localparam int SIG_W = ppgdc_pkg::SIG_W;
  localparam int D_W   = SIG_W + 1;
  localparam int EXT_W = D_W - (X_W + 1) - ppgdc_pkg::FRAC_W;
  localparam int P_W   = D_W + ppgdc_pkg::ALPHA_W + 1;
  localparam int SH_W  = P_W - ppgdc_pkg::ALPHA_W;
  localparam logic signed [P_W-1:0] RND = P_W'(1) << (ppgdc_pkg::ALPHA_W - 1);

  ppgdc_pkg::raw_t         x0;
  ppgdc_pkg::raw_t         last_raw;
  logic signed [X_W:0]     diff;
  logic signed [D_W-1:0]   d;
  logic signed [P_W-1:0]   prod;
  logic signed [P_W-1:0]   rnd;
  logic signed [SH_W-1:0]  sh;
  logic [SH_W-SIG_W:0]     top;
  ppgdc_pkg::sig_t         y_next;

  always_comb begin
    diff   = $signed({1'b0, x0}) - $signed({1'b0, last_raw});
    d      = $signed({y[SIG_W-1], y})
           + $signed({{EXT_W{diff[X_W]}}, diff, {ppgdc_pkg::FRAC_W{1'b0}}});
    prod   = P_W'(d) * P_W'($signed({1'b0, alpha}));
    rnd    = prod + RND;
    sh     = $signed(rnd[P_W-1:ppgdc_pkg::ALPHA_W]);
    top    = sh[SH_W-1:SIG_W-1];
    if ((&top) || !(|top)) begin
      y_next = sh[SIG_W-1:0];
    end else begin
      y_next = sh[SH_W-1] ? ppgdc_pkg::SIG_MIN : ppgdc_pkg::SIG_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x0 <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0   <= 1'b0;
      valid1   <= 1'b0;
      last_raw <= '0;
      y        <= '0;
    end else begin
      valid0 <= take;
      valid1 <= valid0;
      if (valid0) begin
        last_raw <= x0;
        y        <= y_next;
      end
    end
  end

endmodule

[sv/ppgdc_window.sv]
// Boxcar window: shift line, running sum, fill count and rounded magnitude.
// Depends on ppgdc_pkg.
`timescale 1ns / 1ps

module ppgdc_window #(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid1,
  input  ppgdc_pkg::sig_t    y,
  input  logic               smooth,
  output ppgdc_pkg::stg_t    stg2,
  output ppgdc_pkg::sig_t    val2,
  output logic [SUM_W-1:0]   mag2
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int HALF  = WINDOW / 2;

  ppgdc_pkg::sig_t          win [WINDOW];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]         fill;
  logic                     full;
  logic                     take_win;
  logic [SUM_W-1:0]         mag_c;

  always_comb begin
    full     = (fill == CNT_W'(WINDOW));
    take_win = valid1 && smooth;
    sum_next = sum + SUM_W'(y) - (full ? SUM_W'(win[0]) : SUM_W'(0));
    if (sum[SUM_W-1]) begin
      mag_c = ~$unsigned(sum) + SUM_W'(HALF + 1);
    end else begin
      mag_c = $unsigned(sum) + SUM_W'(HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (take_win) begin
      for (int k = 0; k < WINDOW - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[WINDOW-1] <= y;
    end
  end

  always_ff @(posedge clk) begin
    val2 <= y;
    mag2 <= mag_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      sum  <= '0;
      stg2 <= '0;
    end else begin
      stg2.valid  <= valid1 && (!smooth || full);
      stg2.bypass <= !smooth;
      stg2.neg    <= sum[SUM_W-1];
      if (take_win) begin
        sum <= sum_next;
      end
      if (take_win && !full) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

endmodule

[sv/ppgdc_mean.sv]
// Divide the rounded window magnitude by WINDOW: reciprocal multiply in
// two partial products, then sum, shift and sign. Depends on ppgdc_pkg.
`timescale 1ns / 1ps

module ppgdc_mean #(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ppgdc_pkg::stg_t    stg2,
  input  ppgdc_pkg::sig_t    val2,
  input  logic [SUM_W-1:0]   mag2,
  output logic               valid3,
  output logic               res_valid,
  output ppgdc_pkg::sig_t    res_value
);

  localparam int SIG_W  = ppgdc_pkg::SIG_W;
  localparam int L      = $clog2(WINDOW);
  localparam int DIV_S  = SUM_W + L;
  localparam int M_W    = SUM_W + 2;
  localparam int LO_W   = SUM_W / 2;
  localparam int HI_W   = SUM_W - LO_W;
  localparam int PROD_W = SUM_W + M_W;
  localparam logic [63:0] DIV_M64 =
    ((64'd1 << DIV_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [M_W-1:0] DIV_M = DIV_M64[M_W-1:0];

  ppgdc_pkg::stg_t          stg3;
  ppgdc_pkg::stg_t          stg4;
  ppgdc_pkg::sig_t          val3;
  ppgdc_pkg::sig_t          val4;
  logic [LO_W+M_W-1:0]      pp_lo;
  logic [HI_W+M_W-1:0]      pp_hi;
  logic [PROD_W-1:0]        prod;
  logic [SIG_W-1:0]         q4;

  assign prod = (PROD_W'(pp_hi) << LO_W) + PROD_W'(pp_lo);

  always_ff @(posedge clk) begin
    pp_lo <= (LO_W+M_W)'(mag2[LO_W-1:0]) * (LO_W+M_W)'(DIV_M);
    pp_hi <= (HI_W+M_W)'(mag2[SUM_W-1:LO_W]) * (HI_W+M_W)'(DIV_M);
    val3  <= val2;
    q4    <= prod[DIV_S +: SIG_W];
    val4  <= val3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg3 <= '0;
      stg4 <= '0;
    end else begin
      stg3 <= stg2;
      stg4 <= stg3;
    end
  end

  always_comb begin
    valid3    = stg3.valid;
    res_valid = stg4.valid;
    if (stg4.bypass) begin
      res_value = val4;
    end else if (stg4.neg) begin
      res_value = $signed(~q4 + SIG_W'(1));
    end else begin
      res_value = $signed(q4);
    end
  end

endmodule

[sv/ppgdc_fifo.sv]
// Output queue that decouples the result port from the pipeline.
// Depends on ppgdc_pkg.
`timescale 1ns / 1ps

module ppgdc_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ppgdc_pkg::sig_t    push_data,
  input  logic               pop,
  output logic               out_valid,
  output ppgdc_pkg::sig_t    out_data,
  output ppgdc_pkg::fcnt_t   count
);

  localparam int AW = ppgdc_pkg::FIFO_AW;

  ppgdc_pkg::sig_t    mem [ppgdc_pkg::FIFO_D];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + ppgdc_pkg::FIFO_CW'(1);
        2'b01:   count <= count - ppgdc_pkg::FIFO_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/ppg_dc_block_and_boxcar_smoother.sv]
// PPG DC blocker with boxcar smoother, top level.
// A result passes the input register, filter, window and divide stage registers and the output queue.
// Throughput: one item per cycle while sample_stall is low, set by the single multiply-add of the filter recursion;
// an 8-entry output queue absorbs result stalls, sample_stall rises when it could fill.
// Reset (rst, synchronous): clears pipeline, filter history, window sum and fill count,
// loads alpha = 31130 and smoothing on; window contents are not cleared.
`timescale 1ns / 1ps

module ppg_dc_block_and_boxcar_smoother #(
  parameter int WINDOW = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic [17:0]          sample_in,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic signed [27:0]   signal_out,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int SUM_W = ppgdc_pkg::SIG_W + $clog2(WINDOW);
  localparam int CW    = ppgdc_pkg::FIFO_CW;

  ppgdc_pkg::cfg_t    cfg;
  ppgdc_pkg::stg_t    stg2;
  ppgdc_pkg::sig_t    y;
  ppgdc_pkg::sig_t    val2;
  ppgdc_pkg::sig_t    res_value;
  ppgdc_pkg::fcnt_t   count;
  logic [SUM_W-1:0]   mag2;
  logic               take;
  logic               valid0;
  logic               valid1;
  logic               valid3;
  logic               res_valid;
  logic               pop;
  logic [CW-1:0]      occ;

  assign occ = count + CW'(valid0) + CW'(valid1) + CW'(stg2.valid)
             + CW'(valid3) + CW'(res_valid);
  assign sample_stall = rst || (occ >= CW'(ppgdc_pkg::FIFO_D));
  assign take = sample_valid && !sample_stall;
  assign pop  = result_valid && !result_stall;

  ppgdc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppgdc_filter u_filter (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .sample (sample_in),
    .alpha  (cfg.alpha),
    .valid0 (valid0),
    .valid1 (valid1),
    .y      (y)
  );

  ppgdc_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .valid1 (valid1),
    .y      (y),
    .smooth (cfg.smooth),
    .stg2   (stg2),
    .val2   (val2),
    .mag2   (mag2)
  );

  ppgdc_mean #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_mean (
    .clk       (clk),
    .rst       (rst),
    .stg2      (stg2),
    .val2      (val2),
    .mag2      (mag2),
    .valid3    (valid3),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  ppgdc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_value),
    .pop       (pop),
    .out_valid (result_valid),
    .out_data  (signal_out),
    .count     (count)
  );

endmodule

[sv/ppgdc_checker.sv]
// Port-level checker for the PPG DC blocker and its bind to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppgdc_checker (
  input logic                clk,
  input logic                rst,
  input logic                sample_valid,
  input logic                sample_stall,
  input logic                result_valid,
  input logic                result_stall,
  input logic signed [27:0]  signal_out
);

  `PPG_ASSERT_NR(a_reset_empty, clk, $past(rst) |-> !result_valid)
  `PPG_ASSERT(a_latency, clk, rst, !$past(rst) && $rose(result_valid) |-> $past(sample_valid && !sample_stall, 6))
  `PPG_ASSERT(a_valid_hold, clk, rst, !$past(rst) && $past(result_valid && result_stall) |-> result_valid)
  `PPG_ASSERT(a_data_hold, clk, rst, !$past(rst) && $past(result_valid && result_stall) |-> $stable(signal_out))

endmodule

bind ppg_dc_block_and_boxcar_smoother ppgdc_checker u_checker (.*);
